[hw/rtl/cls_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cls_pkg
// Shared types, constants and helpers of the circular list slot engine.
// ----------------------------------------------------------------------------
package cls_pkg;

    localparam int SLOTS     = 32;
    localparam int SLOT_W    = 5;
    localparam int CNT_W     = 6;
    localparam int KEY_BYTES = 20;
    localparam int KEY_W     = 8 * KEY_BYTES;
    localparam int PAY_W     = 32;
    localparam int FUNC_W    = 3;
    localparam int STAT_W    = 2;

    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [PAY_W-1:0]  payload;
        logic [SLOT_W-1:0] nxt;
        logic [SLOT_W-1:0] prv;
    } row_t;

    localparam int ROW_W = $bits(row_t);

    typedef enum logic [FUNC_W-1:0] {
        FN_CLEAR  = 3'd0,
        FN_INSERT = 3'd1,
        FN_FIND   = 3'd2,
        FN_RENAME = 3'd3,
        FN_REMOVE = 3'd4,
        FN_NEXT   = 3'd5,
        FN_PREV   = 3'd6,
        FN_NOP    = 3'd7
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_BADSLOT  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_WRC,
        S_INS_WRN,
        S_INS_WRS,
        S_FIND_CMP,
        S_NAV,
        S_REM_D,
        S_REM_SCAN,
        S_DONE
    } state_t;

    // Zero every byte after the first zero byte.
    function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] k);
        logic             ended;
        logic [7:0]       b;
        logic [KEY_W-1:0] r;
        ended = 1'b0;
        r     = '0;
        for (int i = 0; i < KEY_BYTES; i++) begin
            b = k[8*i +: 8];
            if (ended) b = 8'd0;
            if (b == 8'd0) ended = 1'b1;
            r[8*i +: 8] = b;
        end
        return r;
    endfunction

    // Renumber a link after slot d is squeezed out of the pool.
    function automatic logic [SLOT_W-1:0] renum(input logic [SLOT_W-1:0] x,
                                                input logic [SLOT_W-1:0] d);
        return (x >= d && x != '0) ? x - SLOT_W'(1) : x;
    endfunction

endpackage

[hw/rtl/cls_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cls_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/circular_list_slot_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_list_slot_engine
// Keyed circular doubly linked list in a pool of slots, with a cursor.
// ----------------------------------------------------------------------------
// One word in gives one word out. Every slot (key, payload, next and previous
// link) lives in a single RAM row, read one row per cycle with one write per
// cycle. Find and rename walk the ring from the cursor, at most entries_used
// slots; remove makes one pass over the pool that fixes, renumbers and
// compacts the rows.
// A new word is taken while the previous result still waits on the output.
// The RAM needs no clearing after reset.
module circular_list_slot_engine (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [5:0]   cfg_wdata,     // capacity
    input  logic         s_tvalid,
    output logic         s_tready,
    // key_bytes_low, key_bytes_mid, key_bytes_high, new_key_low, new_key_mid,
    // new_key_high, payload_in, slot_index, zero fill
    input  logic [359:0] s_tdata,
    input  logic [2:0]   s_tuser,       // func
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, found_payload, cursor_slot, cursor_valid, entries_used, zero fill
    output logic [47:0]  m_tdata
);

    localparam int SW = cls_pkg::SLOT_W;
    localparam int CW = cls_pkg::CNT_W;

    cls_pkg::state_t            state_reg, state_next;
    cls_pkg::func_t             func_reg;
    logic [cls_pkg::KEY_W-1:0]  key_reg, newkey_reg;
    logic [cls_pkg::PAY_W-1:0]  pay_reg;
    logic [SW-1:0]              slot_reg;
    logic [CW-1:0]              cap_reg;
    logic [SW-1:0]              cursor_reg, cursor_next;
    logic [SW-1:0]              first_reg, first_next;
    logic                       nonempty_reg, nonempty_next;
    logic [CW-1:0]              used_reg, used_next;
    logic [SW-1:0]              idx_reg, idx_next;
    logic [SW-1:0]              cur_reg, cur_next;
    logic [SW-1:0]              aux_reg, aux_next;
    logic [SW-1:0]              pd_reg, pd_next;
    logic [SW-1:0]              nd_reg, nd_next;
    cls_pkg::status_t           status_reg, status_next;
    logic [cls_pkg::PAY_W-1:0]  found_reg, found_next;
    logic                       m_valid_reg, m_valid_next;
    logic [47:0]                m_data_reg, m_data_next;

    logic                       ram_we;
    logic [SW-1:0]              ram_waddr, ram_raddr;
    cls_pkg::row_t              ram_wdata, ram_rdata;
    logic [CW-1:0]              cap_eff;
    logic [SW-1:0]              c_tmp, f_tmp;
    cls_pkg::row_t              fix_row;
    logic                       out_free;

    cls_ram #(
        .WIDTH(cls_pkg::ROW_W),
        .DEPTH(cls_pkg::SLOTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == cls_pkg::S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign cap_eff  = (cap_reg > cls_pkg::SLOTS_C) ? cls_pkg::SLOTS_C : cap_reg;
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= cls_pkg::SLOTS_C;
        end else if (cfg_we) begin
            cap_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            func_reg   <= cls_pkg::func_t'(s_tuser);
            key_reg    <= cls_pkg::norm_key(s_tdata[159:0]);
            newkey_reg <= cls_pkg::norm_key(s_tdata[319:160]);
            pay_reg    <= s_tdata[351:320];
            slot_reg   <= s_tdata[356:352];
        end
        idx_reg    <= idx_next;
        cur_reg    <= cur_next;
        aux_reg    <= aux_next;
        pd_reg     <= pd_next;
        nd_reg     <= nd_next;
        found_reg  <= found_next;
        status_reg <= status_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= cls_pkg::S_IDLE;
            cursor_reg   <= '0;
            first_reg    <= '0;
            nonempty_reg <= 1'b0;
            used_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cursor_reg   <= cursor_next;
            first_reg    <= first_next;
            nonempty_reg <= nonempty_next;
            used_reg     <= used_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cls_pkg::S_IDLE: begin
                if (s_tvalid) state_next = cls_pkg::S_DECODE;
            end
            cls_pkg::S_DECODE: begin
                state_next = cls_pkg::S_DONE;
                case (func_reg)
                    cls_pkg::FN_INSERT: begin
                        if (used_reg < cap_eff && nonempty_reg)
                            state_next = cls_pkg::S_INS_WRC;
                    end
                    cls_pkg::FN_FIND, cls_pkg::FN_RENAME: begin
                        if (nonempty_reg) state_next = cls_pkg::S_FIND_CMP;
                    end
                    cls_pkg::FN_REMOVE: begin
                        if ({1'b0, slot_reg} < used_reg && used_reg > CW'(1))
                            state_next = cls_pkg::S_REM_D;
                    end
                    cls_pkg::FN_NEXT, cls_pkg::FN_PREV: begin
                        if (nonempty_reg) state_next = cls_pkg::S_NAV;
                    end
                    default: state_next = cls_pkg::S_DONE;
                endcase
            end
            cls_pkg::S_INS_WRC: begin
                state_next = (ram_rdata.nxt == cursor_reg) ? cls_pkg::S_INS_WRS
                                                          : cls_pkg::S_INS_WRN;
            end
            cls_pkg::S_INS_WRN: state_next = cls_pkg::S_INS_WRS;
            cls_pkg::S_INS_WRS: state_next = cls_pkg::S_DONE;
            cls_pkg::S_FIND_CMP: begin
                if (ram_rdata.key == key_reg || {1'b0, idx_reg} == used_reg - CW'(1))
                    state_next = cls_pkg::S_DONE;
            end
            cls_pkg::S_NAV:   state_next = cls_pkg::S_DONE;
            cls_pkg::S_REM_D: state_next = cls_pkg::S_REM_SCAN;
            cls_pkg::S_REM_SCAN: begin
                if ({1'b0, idx_reg} == used_reg - CW'(1)) state_next = cls_pkg::S_DONE;
            end
            cls_pkg::S_DONE: begin
                if (out_free) state_next = cls_pkg::S_IDLE;
            end
            default: state_next = cls_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        cursor_next   = cursor_reg;
        first_next    = first_reg;
        nonempty_next = nonempty_reg;
        used_next     = used_reg;
        idx_next      = idx_reg;
        cur_next      = cur_reg;
        aux_next      = aux_reg;
        pd_next       = pd_reg;
        nd_next       = nd_reg;
        status_next   = status_reg;
        found_next    = found_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        ram_we        = 1'b0;
        ram_waddr     = cursor_reg;
        ram_wdata     = ram_rdata;
        ram_raddr     = cursor_reg;
        c_tmp         = cursor_reg;
        f_tmp         = first_reg;
        fix_row       = ram_rdata;

        case (state_reg)
            cls_pkg::S_DECODE: begin
                status_next = cls_pkg::ST_OK;
                found_next  = '0;
                idx_next    = '0;
                cur_next    = cursor_reg;
                case (func_reg)
                    cls_pkg::FN_CLEAR: begin
                        cursor_next   = '0;
                        first_next    = '0;
                        nonempty_next = 1'b0;
                        used_next     = '0;
                    end
                    cls_pkg::FN_INSERT: begin
                        if (used_reg >= cap_eff) begin
                            status_next = cls_pkg::ST_FULL;
                        end else if (!nonempty_reg) begin
                            ram_we            = 1'b1;
                            ram_waddr         = used_reg[SW-1:0];
                            ram_wdata.key     = key_reg;
                            ram_wdata.payload = pay_reg;
                            ram_wdata.nxt     = used_reg[SW-1:0];
                            ram_wdata.prv     = used_reg[SW-1:0];
                            first_next        = used_reg[SW-1:0];
                            cursor_next       = used_reg[SW-1:0];
                            nonempty_next     = 1'b1;
                            used_next         = used_reg + CW'(1);
                        end
                    end
                    cls_pkg::FN_FIND, cls_pkg::FN_RENAME,
                    cls_pkg::FN_NEXT, cls_pkg::FN_PREV: begin
                        if (!nonempty_reg) status_next = cls_pkg::ST_NOTFOUND;
                    end
                    cls_pkg::FN_REMOVE: begin
                        ram_raddr = slot_reg;
                        if ({1'b0, slot_reg} >= used_reg) begin
                            status_next = cls_pkg::ST_BADSLOT;
                        end else if (used_reg <= CW'(1)) begin
                            cursor_next   = '0;
                            first_next    = '0;
                            nonempty_next = 1'b0;
                            used_next     = '0;
                        end
                    end
                    default: status_next = cls_pkg::ST_OK;
                endcase
            end
            cls_pkg::S_INS_WRC: begin
                aux_next  = ram_rdata.nxt;
                ram_we    = 1'b1;
                ram_waddr = cursor_reg;
                ram_wdata.nxt = used_reg[SW-1:0];
                if (ram_rdata.nxt == cursor_reg) ram_wdata.prv = used_reg[SW-1:0];
                ram_raddr = ram_rdata.nxt;
            end
            cls_pkg::S_INS_WRN: begin
                ram_we        = 1'b1;
                ram_waddr     = aux_reg;
                ram_wdata.prv = used_reg[SW-1:0];
            end
            cls_pkg::S_INS_WRS: begin
                ram_we            = 1'b1;
                ram_waddr         = used_reg[SW-1:0];
                ram_wdata.key     = key_reg;
                ram_wdata.payload = pay_reg;
                ram_wdata.nxt     = aux_reg;
                ram_wdata.prv     = cursor_reg;
                cursor_next       = used_reg[SW-1:0];
                used_next         = used_reg + CW'(1);
            end
            cls_pkg::S_FIND_CMP: begin
                ram_raddr = ram_rdata.nxt;
                if (ram_rdata.key == key_reg) begin
                    if (func_reg == cls_pkg::FN_FIND) begin
                        cursor_next = cur_reg;
                        found_next  = ram_rdata.payload;
                    end else begin
                        ram_we        = 1'b1;
                        ram_waddr     = cur_reg;
                        ram_wdata.key = newkey_reg;
                    end
                end else if ({1'b0, idx_reg} == used_reg - CW'(1)) begin
                    status_next = cls_pkg::ST_NOTFOUND;
                end else begin
                    cur_next = ram_rdata.nxt;
                    idx_next = idx_reg + SW'(1);
                end
            end
            cls_pkg::S_NAV: begin
                cursor_next = (func_reg == cls_pkg::FN_NEXT) ? ram_rdata.nxt
                                                            : ram_rdata.prv;
            end
            cls_pkg::S_REM_D: begin
                pd_next = ram_rdata.prv;
                nd_next = ram_rdata.nxt;
                if (cursor_reg == slot_reg)
                    c_tmp = (first_reg == slot_reg) ? ram_rdata.nxt : ram_rdata.prv;
                if (first_reg == slot_reg) f_tmp = ram_rdata.nxt;
                cursor_next = cls_pkg::renum(c_tmp, slot_reg);
                first_next  = cls_pkg::renum(f_tmp, slot_reg);
                ram_raddr   = '0;
                idx_next    = '0;
            end
            cls_pkg::S_REM_SCAN: begin
                if (ram_rdata.prv == slot_reg) fix_row.prv = pd_reg;
                if (ram_rdata.nxt == slot_reg) fix_row.nxt = nd_reg;
                fix_row.prv = cls_pkg::renum(fix_row.prv, slot_reg);
                fix_row.nxt = cls_pkg::renum(fix_row.nxt, slot_reg);
                ram_wdata   = fix_row;
                ram_we      = (idx_reg != slot_reg);
                ram_waddr   = (idx_reg > slot_reg) ? idx_reg - SW'(1) : idx_reg;
                ram_raddr   = idx_reg + SW'(1);
                idx_next    = idx_reg + SW'(1);
                if ({1'b0, idx_reg} == used_reg - CW'(1)) used_next = used_reg - CW'(1);
            end
            cls_pkg::S_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {2'b00, used_reg, nonempty_reg,
                                    nonempty_reg ? cursor_reg : SW'(0),
                                    found_reg, status_reg};
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the circular list slot engine.
// ----------------------------------------------------------------------------
// Drives list operations with random idle and stall phases across several
// capacity settings. A scoreboard class keeps its own copy of the pool, ring
// and cursor, predicts the result of every accepted word, and checks each
// result word field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
    import cls_pkg::*;

    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic [4:0]  slot_index;
        logic [31:0] payload_in;
        logic [31:0] new_high;
        logic [63:0] new_mid;
        logic [63:0] new_low;
        logic [31:0] key_high;
        logic [63:0] key_mid;
        logic [63:0] key_low;
    } op_word_t;

    typedef struct packed {
        logic [5:0]  entries_used;
        logic        cursor_valid;
        logic [4:0]  cursor_slot;
        logic [31:0] found_payload;
        logic [1:0]  status;
    } list_result_t;

    class list_scoreboard;
        logic [KEY_W-1:0] keys[SLOTS];
        logic [31:0]      pays[SLOTS];
        logic [4:0]       nxt[SLOTS];
        logic [4:0]       prv[SLOTS];
        logic [4:0]       cursor;
        logic [4:0]       first;
        bit               nonempty;
        int               used;
        int               capacity;
        list_result_t     pending[$];
        int               errors;

        function new();
            capacity = 32;
            errors = 0;
            wipe();
        endfunction

        function void wipe();
            for (int i = 0; i < SLOTS; i++) begin
                keys[i] = '0;
                pays[i] = '0;
                nxt[i] = '0;
                prv[i] = '0;
            end
            cursor = '0;
            first = '0;
            nonempty = 0;
            used = 0;
        endfunction

        function logic [KEY_W-1:0] clip_key(logic [KEY_W-1:0] k);
            logic [KEY_W-1:0] r;
            bit ended;
            r = '0;
            ended = 0;
            for (int i = 0; i < KEY_BYTES; i++) begin
                if (!ended && k[8*i +: 8] != 8'd0) r[8*i +: 8] = k[8*i +: 8];
                else ended = 1;
            end
            return r;
        endfunction

        function int locate(logic [KEY_W-1:0] k);
            logic [4:0] idx;
            if (!nonempty) return -1;
            idx = cursor;
            for (int n = 0; n < used; n++) begin
                if (keys[idx] == k) return idx;
                idx = nxt[idx];
            end
            return -1;
        endfunction

        function void note_word(func_t fn, op_word_t w);
            list_result_t r;
            logic [KEY_W-1:0] k;
            logic [4:0] c, nx, d;
            int cap, m;
            r = '0;
            r.status = ST_OK;
            cap = capacity < SLOTS ? capacity : SLOTS;
            k = clip_key({w.key_high, w.key_mid, w.key_low});
            case (fn)
                FN_CLEAR: wipe();
                FN_INSERT: begin
                    if (used >= cap) begin
                        r.status = ST_FULL;
                    end else begin
                        c = 5'(used);
                        used++;
                        keys[c] = k;
                        pays[c] = w.payload_in;
                        if (!nonempty) begin
                            nxt[c] = c;
                            prv[c] = c;
                            first = c;
                            nonempty = 1;
                        end else begin
                            nx = nxt[cursor];
                            nxt[c] = nx;
                            prv[c] = cursor;
                            prv[nx] = c;
                            nxt[cursor] = c;
                        end
                        cursor = c;
                    end
                end
                FN_FIND, FN_RENAME: begin
                    m = locate(k);
                    if (m < 0) begin
                        r.status = ST_NOTFOUND;
                    end else if (fn == FN_FIND) begin
                        cursor = 5'(m);
                        r.found_payload = pays[m];
                    end else begin
                        keys[m] = clip_key({w.new_high, w.new_mid, w.new_low});
                    end
                end
                FN_REMOVE: begin
                    d = w.slot_index;
                    if (int'(d) >= used) begin
                        r.status = ST_BADSLOT;
                    end else if (used == 1) begin
                        wipe();
                    end else begin
                        for (int i = 0; i < used; i++) begin
                            if (prv[i] == d) prv[i] = prv[d];
                            if (nxt[i] == d) nxt[i] = nxt[d];
                        end
                        if (cursor == d) cursor = (first == d) ? nxt[d] : prv[d];
                        if (first == d) first = nxt[d];
                        for (int i = d; i < used - 1; i++) begin
                            keys[i] = keys[i+1];
                            pays[i] = pays[i+1];
                            nxt[i] = nxt[i+1];
                            prv[i] = prv[i+1];
                        end
                        used--;
                        for (int i = 0; i < used; i++) begin
                            prv[i] = shift_down(prv[i], d);
                            nxt[i] = shift_down(nxt[i], d);
                        end
                        first = shift_down(first, d);
                        cursor = shift_down(cursor, d);
                    end
                end
                FN_NEXT, FN_PREV: begin
                    if (!nonempty) r.status = ST_NOTFOUND;
                    else cursor = (fn == FN_NEXT) ? nxt[cursor] : prv[cursor];
                end
                default: ;
            endcase
            r.cursor_slot = nonempty ? cursor : 5'd0;
            r.cursor_valid = nonempty;
            r.entries_used = 6'(used);
            pending.push_back(r);
        endfunction

        function logic [4:0] shift_down(logic [4:0] x, logic [4:0] d);
            return (x >= d && x != 0) ? x - 5'd1 : x;
        endfunction

        function void check_word(list_result_t got);
            list_result_t e;
            if (pending.size() == 0) begin
                $error("unexpected result word %h", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status) begin
                $error("status exp %0d got %0d", e.status, got.status); errors++;
            end
            if (got.found_payload !== e.found_payload) begin
                $error("found_payload exp %h got %h", e.found_payload, got.found_payload);
                errors++;
            end
            if (got.cursor_slot !== e.cursor_slot) begin
                $error("cursor_slot exp %0d got %0d", e.cursor_slot, got.cursor_slot);
                errors++;
            end
            if (got.cursor_valid !== e.cursor_valid) begin
                $error("cursor_valid exp %0d got %0d", e.cursor_valid, got.cursor_valid);
                errors++;
            end
            if (got.entries_used !== e.entries_used) begin
                $error("entries_used exp %0d got %0d", e.entries_used, got.entries_used);
                errors++;
            end
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic [5:0]   cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [359:0] s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [47:0]  m_tdata;

    list_scoreboard sb;
    int send_idle;
    int recv_stall;
    int quiet_cycles;
    logic [KEY_W-1:0] key_pool[8];

    circular_list_slot_engine u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            m_tready <= ($urandom_range(99) >= recv_stall);
            if (m_tvalid && m_tready) sb.check_word(list_result_t'(m_tdata[45:0]));
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG) begin
                $display("circular_list_slot_engine: mismatch");
                $finish;
            end
        end
    end

    function automatic logic [KEY_W-1:0] random_key();
        logic [KEY_W-1:0] k;
        for (int i = 0; i < KEY_BYTES; i++) k[8*i +: 8] = 8'($urandom);
        case ($urandom_range(3))
            0: k[8*$urandom_range(KEY_BYTES-1) +: 8] = 8'd0;
            1: k[8*$urandom_range(KEY_BYTES-1) +: 8] = 8'd0;
            default: ;
        endcase
        return k;
    endfunction

    task automatic send_word(func_t fn, logic [KEY_W-1:0] key,
                             logic [KEY_W-1:0] new_key, logic [31:0] pay,
                             logic [4:0] slot);
        op_word_t w;
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        w.key_low = key[63:0];
        w.key_mid = key[127:64];
        w.key_high = key[159:128];
        w.new_low = new_key[63:0];
        w.new_mid = new_key[127:64];
        w.new_high = new_key[159:128];
        w.payload_in = pay;
        w.slot_index = slot;
        s_tvalid <= 1'b1;
        s_tuser <= fn;
        s_tdata <= {3'd0, w};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_word(fn, w);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic write_capacity(logic [5:0] value);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.capacity = value;
    endtask

    task automatic random_word();
        func_t fn;
        logic [KEY_W-1:0] k, nk;
        int p;
        p = $urandom_range(99);
        if (p < 3) fn = FN_CLEAR;
        else if (p < 35) fn = FN_INSERT;
        else if (p < 55) fn = FN_FIND;
        else if (p < 63) fn = FN_RENAME;
        else if (p < 80) fn = FN_REMOVE;
        else if (p < 89) fn = FN_NEXT;
        else if (p < 98) fn = FN_PREV;
        else fn = FN_NOP;
        k = ($urandom_range(3) != 0) ? key_pool[$urandom_range(7)] : random_key();
        nk = ($urandom_range(1) != 0) ? key_pool[$urandom_range(7)] : random_key();
        if (fn == FN_INSERT && $urandom_range(1) != 0) key_pool[$urandom_range(7)] = k;
        send_word(fn, k, nk, $urandom,
                  ($urandom_range(3) != 0 && sb.used > 0) ?
                  5'($urandom_range(sb.used - 1)) : 5'($urandom));
    endtask

    initial begin
        logic [KEY_W-1:0] ones;
        sb = new();
        send_idle = 0;
        recv_stall = 0;
        quiet_cycles = 0;
        ones = '1;
        for (int i = 0; i < 8; i++) key_pool[i] = random_key();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_word(FN_FIND, ones, '0, '0, '0);
        send_word(FN_RENAME, ones, '0, '0, '0);
        send_word(FN_NEXT, '0, '0, '0, '0);
        send_word(FN_PREV, '0, '0, '0, '0);
        send_word(FN_REMOVE, '0, '0, '0, 5'd0);
        send_word(FN_INSERT, ones, '0, '1, 5'd31);
        send_word(FN_INSERT, '0, '0, 32'h0, '0);
        send_word(FN_INSERT, {152'd0, 8'h41}, '0, 32'h1234, '0);
        send_word(FN_FIND, ones, '0, '0, '0);
        send_word(FN_FIND, {ones[159:16], 16'h0041}, '0, '0, '0);
        send_word(FN_RENAME, '0, ones, '0, '0);
        send_word(FN_NEXT, '0, '0, '0, '0);
        send_word(FN_PREV, '0, '0, '0, '0);
        send_word(FN_REMOVE, '0, '0, '0, 5'd31);
        send_word(FN_REMOVE, '0, '0, '0, 5'd1);
        send_word(FN_NOP, ones, ones, '1, '1);
        send_word(FN_REMOVE, '0, '0, '0, 5'd0);
        send_word(FN_REMOVE, '0, '0, '0, 5'd0);
        send_word(FN_CLEAR, '0, '0, '0, '0);

        write_capacity(6'd1);
        send_word(FN_INSERT, ones, '0, 32'h5, '0);
        send_word(FN_INSERT, ones, '0, 32'h6, '0);
        write_capacity(6'd0);
        send_word(FN_INSERT, ones, '0, 32'h7, '0);
        send_word(FN_CLEAR, '0, '0, '0, '0);

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 85; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 85; end
                default: begin send_idle = 6; recv_stall = 6; end
            endcase
            case (ph)
                0: write_capacity(6'd32);
                1: write_capacity(6'd63);
                2: write_capacity(6'd4);
                3: write_capacity(6'd2);
                4: write_capacity(6'($urandom_range(1, 32)));
                5: write_capacity(6'd33);
                6: write_capacity(6'd16);
                default: write_capacity(6'd32);
            endcase
            for (int i = 0; i < 200; i++) begin
                if (i == 100) drain();
                random_word();
            end
        end

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("circular_list_slot_engine: match");
        else
            $display("circular_list_slot_engine: mismatch");
        $finish;
    end
endmodule
